[src/rvde_pkg.sv]
// ----------------------------------------------------------------------------
// rvde_pkg
// Shared types and encodings for the RV32I decode and execute block.
// ----------------------------------------------------------------------------
package rvde_pkg;

    // major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    // simulator stop word
    localparam logic [31:0] STOP_WORD = 32'h0FF0_0513;

    // funct7 values
    localparam logic [6:0] FUNCT7_BASE = 7'h00;
    localparam logic [6:0] FUNCT7_ALT  = 7'h20;

    // funct3 of the integer ops
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 of jalr, loads, stores
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;

    // funct3 of branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // memory access kinds
    typedef logic [3:0] mem_kind_t;
    localparam mem_kind_t MEM_NONE = 4'd0;
    localparam mem_kind_t MEM_LB   = 4'd1;
    localparam mem_kind_t MEM_LH   = 4'd2;
    localparam mem_kind_t MEM_LW   = 4'd3;
    localparam mem_kind_t MEM_LBU  = 4'd4;
    localparam mem_kind_t MEM_LHU  = 4'd5;
    localparam mem_kind_t MEM_SB   = 4'd6;
    localparam mem_kind_t MEM_SH   = 4'd7;
    localparam mem_kind_t MEM_SW   = 4'd8;

    // instruction class handed from front to back
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ALU,
        OP_ALUI,
        OP_JALR,
        OP_LOAD,
        OP_STORE,
        OP_BRANCH,
        OP_LUI,
        OP_AUIPC,
        OP_JAL
    } op_class_t;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLL,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_SRL,
        ALU_SRA,
        ALU_OR,
        ALU_AND
    } alu_op_t;

    // input item
    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] instr_pc;
        logic [31:0] src1_value;
        logic [31:0] src2_value;
    } instr_t;

    // result item
    typedef struct packed {
        logic        illegal;
        logic        halt;
        logic [4:0]  dest_index;
        logic [4:0]  src1_index;
        logic [4:0]  src2_index;
        logic        writes_dest;
        logic [31:0] dest_value;
        logic        branch_taken;
        logic [31:0] next_pc;
        mem_kind_t   mem_kind;
        logic [31:0] mem_address;
        logic [31:0] store_data;
    } result_t;

    // decoded instruction waiting in the queue
    typedef struct packed {
        op_class_t   op_class;
        alu_op_t     alu_op;
        logic [2:0]  funct3;
        mem_kind_t   mem_kind;
        logic        illegal;
        logic        halt;
        logic        writes_dest;
        logic [4:0]  dest_index;
        logic [4:0]  src1_index;
        logic [4:0]  src2_index;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [31:0] src1_value;
        logic [31:0] src2_value;
    } dec_t;

endpackage

[src/rvde_chan_if.sv]
// ----------------------------------------------------------------------------
// rvde_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface rvde_chan_if #(
    parameter type T = logic [31:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/rv32i_decode_execute.sv]
// ----------------------------------------------------------------------------
// rv32i_decode_execute
// RV32I decode and execute: one instruction item in, one result item out.
// ----------------------------------------------------------------------------
// Accepts one instruction item per clock and returns one result item per
// clock when the result side keeps up. An accepted item is written into the
// queue, then into the result register once that register is empty or being
// taken, and its result is valid while it sits there. The rate is set by
// the combinational decode in the front and the combinational adder,
// shifter and compare in the back; the queue (QUEUE_DEPTH entries) plus
// the output register let the input side keep accepting while a result
// waits, holding up to QUEUE_DEPTH + 1 items in flight. Illegal encodings
// report illegal with next_pc = pc + 4; the stop word reports halt and
// holds next_pc at pc.
module rv32i_decode_execute #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    rvde_chan_if.sink   instr,
    rvde_chan_if.source result
);
    import rvde_pkg::*;

    dec_t push_data;
    dec_t head_data;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    // decode and classify
    rvde_front u_front (
        .instr (instr),
        .full  (full),
        .push  (push),
        .dec   (push_data)
    );

    // decoupling queue
    rvde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // execute and hold result
    rvde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .result     (result)
    );

`ifndef NO_ASSERTIONS
    // an illegal item writes nothing and touches no memory
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.illegal) |->
        (!result.data.writes_dest && result.data.mem_kind == MEM_NONE &&
         !result.data.branch_taken))
        else $error("illegal item has side effects");
    // a register write never targets x0
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.writes_dest) |-> (result.data.dest_index != 5'd0))
        else $error("write to x0");
    // the stop word decodes as legal but is not executed
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.halt) |->
        (!result.data.illegal && !result.data.writes_dest && result.data.dest_index == 5'd0))
        else $error("halt item not suppressed");
    // memory accesses never also write through the ALU path
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.mem_kind != MEM_NONE) |-> !result.data.writes_dest)
        else $error("memory access with register write");
`endif

endmodule

[src/rvde_front.sv]
// ----------------------------------------------------------------------------
// rvde_front
// Accepts instruction items, decodes format, immediate and legality, and
// pushes the classified instruction into the queue.
// ----------------------------------------------------------------------------
module rvde_front (
    rvde_chan_if.sink       instr,
    input  logic            full,
    output logic            push,
    output rvde_pkg::dec_t  dec
);
    import rvde_pkg::*;

    logic [31:0] w;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic        is_halt;
    op_class_t   cls;
    alu_op_t     alu;
    mem_kind_t   kind;
    logic        ill;
    logic        wr;
    logic [4:0]  di;
    logic [4:0]  s1;
    logic [4:0]  s2;
    logic [31:0] imm;

    // alu operation for the plain funct3 encodings
    function automatic alu_op_t base_op(input logic [2:0] code);
        alu_op_t op;
        unique case (code)
            F3_ADD:  op = ALU_ADD;
            F3_SLL:  op = ALU_SLL;
            F3_SLT:  op = ALU_SLT;
            F3_SLTU: op = ALU_SLTU;
            F3_XOR:  op = ALU_XOR;
            F3_SR:   op = ALU_SRL;
            F3_OR:   op = ALU_OR;
            default: op = ALU_AND;
        endcase
        return op;
    endfunction

    // handshake: take an item whenever the queue has room
    assign instr.ready = !full;
    assign push        = instr.valid && !full;

    // instruction fields and immediates
    assign w     = instr.data.instr_word;
    assign opc   = w[6:0];
    assign rd    = w[11:7];
    assign f3    = w[14:12];
    assign rs1   = w[19:15];
    assign rs2   = w[24:20];
    assign f7    = w[31:25];
    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u = {w[31:12], 12'h000};
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign is_halt = (w == STOP_WORD);

    // opcode decode
    always_comb
    begin
        cls  = OP_NONE;
        alu  = ALU_ADD;
        kind = MEM_NONE;
        ill  = 1'b0;
        wr   = 1'b0;
        di   = '0;
        s1   = '0;
        s2   = '0;
        imm  = '0;
        unique case (opc)
            OPC_OP:
            begin
                cls = OP_ALU;
                s1  = rs1;
                s2  = rs2;
                di  = rd;
                wr  = 1'b1;
                if (f7 == FUNCT7_BASE)
                begin
                    alu = base_op(f3);
                end
                else if (f7 == FUNCT7_ALT && f3 == F3_ADD)
                begin
                    alu = ALU_SUB;
                end
                else if (f7 == FUNCT7_ALT && f3 == F3_SR)
                begin
                    alu = ALU_SRA;
                end
                else
                begin
                    ill = 1'b1;
                end
            end
            OPC_OPIMM:
            begin
                cls = OP_ALUI;
                s1  = rs1;
                di  = rd;
                wr  = 1'b1;
                imm = imm_i;
                alu = base_op(f3);
                if (f3 == F3_SLL && f7 != FUNCT7_BASE)
                begin
                    ill = 1'b1;
                end
                if (f3 == F3_SR)
                begin
                    if (f7 == FUNCT7_ALT)
                    begin
                        alu = ALU_SRA;
                    end
                    else if (f7 != FUNCT7_BASE)
                    begin
                        ill = 1'b1;
                    end
                end
            end
            OPC_JALR:
            begin
                cls = OP_JALR;
                s1  = rs1;
                di  = rd;
                wr  = 1'b1;
                imm = imm_i;
                ill = (f3 != F3_JALR);
            end
            OPC_LOAD:
            begin
                cls = OP_LOAD;
                s1  = rs1;
                di  = rd;
                imm = imm_i;
                unique case (f3)
                    F3_LB:   kind = MEM_LB;
                    F3_LH:   kind = MEM_LH;
                    F3_LW:   kind = MEM_LW;
                    F3_LBU:  kind = MEM_LBU;
                    F3_LHU:  kind = MEM_LHU;
                    default: ill  = 1'b1;
                endcase
            end
            OPC_STORE:
            begin
                cls = OP_STORE;
                s1  = rs1;
                s2  = rs2;
                imm = imm_s;
                unique case (f3)
                    F3_SB:   kind = MEM_SB;
                    F3_SH:   kind = MEM_SH;
                    F3_SW:   kind = MEM_SW;
                    default: ill  = 1'b1;
                endcase
            end
            OPC_BRANCH:
            begin
                cls = OP_BRANCH;
                s1  = rs1;
                s2  = rs2;
                imm = imm_b;
                ill = (f3 == 3'd2) || (f3 == 3'd3);
            end
            OPC_LUI:
            begin
                cls = OP_LUI;
                di  = rd;
                wr  = 1'b1;
                imm = imm_u;
            end
            OPC_AUIPC:
            begin
                cls = OP_AUIPC;
                di  = rd;
                wr  = 1'b1;
                imm = imm_u;
            end
            OPC_JAL:
            begin
                cls = OP_JAL;
                di  = rd;
                wr  = 1'b1;
                imm = imm_j;
            end
            default:
            begin
                ill = 1'b1;
            end
        endcase

        // illegal and stop words do nothing
        if (ill || is_halt)
        begin
            cls  = OP_NONE;
            kind = MEM_NONE;
            wr   = 1'b0;
            di   = '0;
            s1   = '0;
            s2   = '0;
        end
        if (di == 5'd0)
        begin
            wr = 1'b0;
        end
    end

    // classified instruction for the queue
    always_comb
    begin
        dec.op_class    = cls;
        dec.alu_op      = alu;
        dec.funct3      = f3;
        dec.mem_kind    = kind;
        dec.illegal     = ill;
        dec.halt        = is_halt;
        dec.writes_dest = wr;
        dec.dest_index  = di;
        dec.src1_index  = s1;
        dec.src2_index  = s2;
        dec.imm         = imm;
        dec.pc          = instr.data.instr_pc;
        dec.src1_value  = instr.data.src1_value;
        dec.src2_value  = instr.data.src2_value;
    end

endmodule

[src/rvde_queue.sv]
// ----------------------------------------------------------------------------
// rvde_queue
// Small FIFO of decoded instructions between the front and back parts.
// ----------------------------------------------------------------------------
module rvde_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rvde_pkg::dec_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rvde_pkg::dec_t  head_data
);
    import rvde_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dec_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    // fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    // an entry is only removed when one is present
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue popped while empty");
    // a push into a full queue with no pop would lose an item
    assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |-> !full)
        else $error("queue pushed while full");
`endif

endmodule

[src/rvde_back.sv]
// ----------------------------------------------------------------------------
// rvde_back
// Executes decoded instructions: ALU, branch compare, next pc, address
// generation, and holds each result in an output register.
// ----------------------------------------------------------------------------
module rvde_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  rvde_pkg::dec_t  head_data,
    output logic            pop,
    rvde_chan_if.source     result
);
    import rvde_pkg::*;

    dec_t        d;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] opb;
    logic [4:0]  sh;
    logic        eq;
    logic        lt_s;
    logic        lt_u;
    logic [31:0] alu_res;
    logic [31:0] pc_plus4;
    logic [31:0] pc_imm;
    logic [31:0] a_imm;
    logic        taken;
    result_t     res;
    result_t     result_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    assign d        = head_data;
    assign a        = d.src1_value;
    assign b        = d.src2_value;
    assign opb      = (d.op_class == OP_ALU || d.op_class == OP_BRANCH) ? b : d.imm;
    assign sh       = opb[4:0];
    assign eq       = (a == opb);
    assign lt_s     = ($signed(a) < $signed(opb));
    assign lt_u     = (a < opb);
    assign pc_plus4 = d.pc + 32'd4;
    assign pc_imm   = d.pc + d.imm;
    assign a_imm    = a + d.imm;

    // integer unit
    always_comb
    begin
        unique case (d.alu_op)
            ALU_ADD:  alu_res = a + opb;
            ALU_SUB:  alu_res = a - opb;
            ALU_SLL:  alu_res = a << sh;
            ALU_SLT:  alu_res = {31'd0, lt_s};
            ALU_SLTU: alu_res = {31'd0, lt_u};
            ALU_XOR:  alu_res = a ^ opb;
            ALU_SRL:  alu_res = a >> sh;
            ALU_SRA:  alu_res = $unsigned($signed(a) >>> sh);
            ALU_OR:   alu_res = a | opb;
            default:  alu_res = a & opb;
        endcase
    end

    // branch condition
    always_comb
    begin
        unique case (d.funct3)
            F3_BEQ:  taken = eq;
            F3_BNE:  taken = !eq;
            F3_BLT:  taken = lt_s;
            F3_BGE:  taken = !lt_s;
            F3_BLTU: taken = lt_u;
            F3_BGEU: taken = !lt_u;
            default: taken = 1'b0;
        endcase
        if (d.op_class != OP_BRANCH)
        begin
            taken = 1'b0;
        end
    end

    // result assembly
    always_comb
    begin
        res.illegal      = d.illegal;
        res.halt         = d.halt;
        res.dest_index   = d.dest_index;
        res.src1_index   = d.src1_index;
        res.src2_index   = d.src2_index;
        res.writes_dest  = d.writes_dest;
        res.dest_value   = '0;
        res.branch_taken = taken;
        res.next_pc      = taken ? pc_imm : pc_plus4;
        res.mem_kind     = d.mem_kind;
        res.mem_address  = '0;
        res.store_data   = '0;
        unique case (d.op_class) inside
            OP_ALU, OP_ALUI:
            begin
                res.dest_value = alu_res;
            end
            OP_JAL:
            begin
                res.dest_value = pc_plus4;
                res.next_pc    = pc_imm;
            end
            OP_JALR:
            begin
                res.dest_value = pc_plus4;
                res.next_pc    = {a_imm[31:1], 1'b0};
            end
            OP_LOAD:
            begin
                res.mem_address = a_imm;
            end
            OP_STORE:
            begin
                res.mem_address = a_imm;
                res.store_data  = b;
            end
            OP_LUI:
            begin
                res.dest_value = d.imm;
            end
            OP_AUIPC:
            begin
                res.dest_value = pc_imm;
            end
            OP_NONE:
            begin
                res.next_pc = d.halt ? d.pc : pc_plus4;
            end
            default:
            begin
            end
        endcase
    end

    // output register: refill when empty or being taken
    assign pop            = head_valid && (!out_valid_reg || result.ready);
    assign out_valid_next = pop || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

endmodule
